### src/tcw_pkg.sv
// Shared types, codes and default geometry for the text console writer.
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int CODE_W   = 9;
    localparam int INDEX_W  = 11;
    localparam int POS_W    = 11;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;
    localparam int CHAR_W   = 8;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // Special character codes
    localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;

    // Attribute after reset
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CODE_W-1:0]   char_code;
        logic [INDEX_W-1:0]  cell_index;
    } in_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } out_t;

endpackage

### src/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/text_console_writer_core.sv
// Top level of the text console writer: sequencer around the screen cell RAM.
//
// Usage:
//   s_valid/s_ready/s_data carry one command per transfer: put a character,
//   clear the screen or read one cell. m_valid/m_ready/m_data return exactly
//   one result per command: cursor position, read cell word and scroll flag.
//   cfg_valid/cfg_ready/cfg_data write the attribute byte; cfg_ready is
//   always high, write it only while no command is outstanding.
// Sequence (C = COLUMNS, R = ROWS, all cells live in one RAM, one write a cycle):
//   put without scroll: character write, blank write at the new cursor, then
//     the result load; read: RAM read, then the load; unused code: the load.
//   put with scroll: the row copy moves rows 1..R-2 up one row, one cell per
//     cycle through the RAM's read and write ports; row R-2 is then zeroed,
//     the blank written and the result loaded.
//   clear: every cell zeroed, one per cycle, then the result load.
//   A new command is taken the cycle after the previous result is loaded into
//   the output register; the output register holds while m_ready is low, and
//   the block waits before loading.
// Reset: aresetn low clears the cursor and sets the attribute to 0x0F. After
//   reset a wipe pass zeroes all R*C cells (2000 by default) with s_ready low.
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tcw_pkg::in_t                      s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tcw_pkg::out_t                     m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]        cfg_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int LIMIT  = (ROWS - 1) * COLUMNS;
    localparam int COPY_N = (ROWS - 2) * COLUMNS;
    localparam int AW     = $clog2(CELLS);
    localparam int CW     = $clog2(COLUMNS);

    // Sequencer states
    localparam logic [2:0] ST_WIPE  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_COPY  = 3'd2;
    localparam logic [2:0] ST_ZERO  = 3'd3;
    localparam logic [2:0] ST_BLANK = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;
    localparam logic [2:0] ST_READ  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]                   state_reg, state_next;
    logic [AW-1:0]                cnt_reg, cnt_next;
    logic [AW-1:0]                cursor_reg, cursor_next;
    logic [CW-1:0]                col_reg, col_next;
    logic [tcw_pkg::ATTR_W-1:0]   attr_reg;
    logic                         scrolled_reg, scrolled_next;
    logic [tcw_pkg::CELL_W-1:0]   data_reg, data_next;
    logic                         m_valid_reg, m_valid_next;
    tcw_pkg::out_t                m_data_reg, m_data_next;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
    logic [AW-1:0]                mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]   mem_rdata;

    logic                         s_xfer;
    logic [AW-1:0]                put_pos;
    logic [CW-1:0]                put_col;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Screen cell store
    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Read address: the requested cell when idle, copy source otherwise
    assign mem_raddr = (state_reg == ST_IDLE) ? AW'(s_data.cell_index)
                                              : cnt_reg + AW'(COLUMNS);

    // Cursor motion for a put, before any scroll
    always_comb begin
        put_pos = cursor_reg;
        put_col = col_reg;
        case (s_data.char_code)
            tcw_pkg::CODE_NEWLINE: begin
                put_pos = cursor_reg - AW'(col_reg) + AW'(COLUMNS);
                put_col = '0;
            end
            tcw_pkg::CODE_BACKSPACE: begin
                if (cursor_reg != '0) begin
                    put_pos = cursor_reg - AW'(1);
                    put_col = (col_reg == '0) ? CW'(COLUMNS - 1) : col_reg - CW'(1);
                end
            end
            default: begin
                put_pos = cursor_reg + AW'(1);
                put_col = (col_reg == CW'(COLUMNS - 1)) ? '0 : col_reg + CW'(1);
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cursor_next   = cursor_reg;
        col_next      = col_reg;
        scrolled_next = scrolled_reg;
        data_next     = data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg;
        mem_wdata     = '0;

        unique case (state_reg) inside
            ST_WIPE, ST_CLEAR: begin
                mem_we = 1'b1;
                if (cnt_reg == AW'(CELLS - 1)) begin
                    state_next = (state_reg == ST_WIPE) ? ST_IDLE : ST_DONE;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    scrolled_next = 1'b0;
                    data_next     = '0;
                    cnt_next      = '0;
                    case (s_data.action)
                        tcw_pkg::ACT_PUT: begin
                            if (s_data.char_code != tcw_pkg::CODE_NEWLINE &&
                                s_data.char_code != tcw_pkg::CODE_BACKSPACE) begin
                                mem_we    = 1'b1;
                                mem_waddr = cursor_reg;
                                mem_wdata = {attr_reg, s_data.char_code[tcw_pkg::CHAR_W-1:0]};
                            end
                            col_next = put_col;
                            if (put_pos >= AW'(LIMIT)) begin
                                cursor_next   = put_pos - AW'(COLUMNS);
                                scrolled_next = 1'b1;
                                state_next    = ST_COPY;
                            end else begin
                                cursor_next = put_pos;
                                state_next  = ST_BLANK;
                            end
                        end
                        tcw_pkg::ACT_CLEAR: begin
                            cursor_next = '0;
                            col_next    = '0;
                            state_next  = ST_CLEAR;
                        end
                        tcw_pkg::ACT_READ: begin
                            if (32'(s_data.cell_index) < CELLS) begin
                                state_next = ST_READ;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_COPY: begin
                // read cell cnt+C now, write the one read last cycle to cnt-1
                if (cnt_reg != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg - AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (cnt_reg == AW'(COPY_N)) begin
                    state_next = ST_ZERO;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_ZERO: begin
                mem_we = 1'b1;
                if (cnt_reg == AW'(LIMIT - 1)) begin
                    state_next = ST_BLANK;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_BLANK: begin
                mem_we     = 1'b1;
                mem_waddr  = cursor_reg;
                mem_wdata  = {attr_reg, tcw_pkg::BLANK_CHAR};
                state_next = ST_DONE;
            end
            ST_READ: begin
                data_next  = mem_rdata;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.cursor_pos = tcw_pkg::POS_W'(cursor_reg);
                    m_data_next.cell_data  = data_reg;
                    m_data_next.scrolled   = scrolled_reg;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_WIPE;
            cnt_reg      <= '0;
            cursor_reg   <= '0;
            col_reg      <= '0;
            attr_reg     <= tcw_pkg::ATTR_RESET;
            scrolled_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cursor_reg   <= cursor_next;
            col_reg      <= col_next;
            scrolled_reg <= scrolled_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                attr_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        data_reg   <= data_next;
        m_data_reg <= m_data_next;
    end

    // Cursor never reaches the last row between commands
    assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg < AW'(LIMIT))
        else $error("cursor entered the last row");

    // Column tracker stays inside a row
    assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg < CW'(COLUMNS))
        else $error("column counter out of range");

    // Copy never writes the cell it is reading
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY && mem_we) |-> mem_waddr != mem_raddr)
        else $error("row copy read/write collision");

    // An idle write only comes from an accepted put
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && mem_we) |-> (s_xfer && s_data.action == tcw_pkg::ACT_PUT))
        else $error("stray cell write while idle");

    // A scrolled result leaves the cursor at the start of the second-to-last row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.scrolled) |->
            m_data_reg.cursor_pos == tcw_pkg::POS_W'(COPY_N))
        else $error("cursor after scroll misplaced");

endmodule

### tb/sv/tb_text_console_writer_core.sv
// Self-checking testbench for text_console_writer_core: table-driven and random commands.
`timescale 1ns / 100ps

module tb_text_console_writer_core;

    // Screen geometry as built into the block
    localparam int SCREEN_COLS  = tcw_pkg::COLUMNS_DEF;
    localparam int SCREEN_ROWS  = tcw_pkg::ROWS_DEF;
    localparam int CELL_COUNT   = SCREEN_COLS * SCREEN_ROWS;
    localparam int SCROLL_LIMIT = (SCREEN_ROWS - 1) * SCREEN_COLS;

    // Action code the block must treat as a no-op
    localparam logic [tcw_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int RESET_CYCLES = 12;
    localparam int SEG_ITEMS    = 275;
    localparam int SEG_COUNT    = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 16;
    // Longest quiet stretch: a clear or scroll plus stalls, many times over
    localparam int QUIET_LIMIT  = 40000;

    typedef struct packed {
        tcw_pkg::in_t  cmd;
        logic [5:0]    reps;
        logic          fixed;
        tcw_pkg::out_t want;
    } step_row_t;

    // Directed steps; "fixed" rows carry the result read straight off the spec
    localparam step_row_t DIRECTED_STEPS [0:22] = '{
        '{'{tcw_pkg::ACT_READ, 9'h000, 11'd0}, 6'd1, 1'b1, '{11'd0, 16'h0000, 1'b0}},
        '{'{tcw_pkg::ACT_READ, 9'h000, 11'd2047}, 6'd1, 1'b1, '{11'd0, 16'h0000, 1'b0}},
        '{'{tcw_pkg::ACT_READ, 9'h000, 11'd1999}, 6'd1, 1'b1, '{11'd0, 16'h0000, 1'b0}},
        '{'{tcw_pkg::ACT_PUT, 9'h041, 11'd0}, 6'd1, 1'b1, '{11'd1, 16'h0000, 1'b0}},
        '{'{tcw_pkg::ACT_READ, 9'h000, 11'd0}, 6'd1, 1'b1, '{11'd1, 16'h0F41, 1'b0}},
        '{'{tcw_pkg::ACT_READ, 9'h000, 11'd1}, 6'd1, 1'b1, '{11'd1, 16'h0F20, 1'b0}},
        '{'{tcw_pkg::ACT_PUT, 9'h1FF, 11'd2047}, 6'd1, 1'b1, '{11'd2, 16'h0000, 1'b0}},
        '{'{tcw_pkg::ACT_READ, 9'h1FF, 11'd1}, 6'd1, 1'b1, '{11'd2, 16'h0FFF, 1'b0}},
        '{'{tcw_pkg::ACT_PUT, 9'h000, 11'd0}, 6'd1, 1'b0, '0},
        '{'{tcw_pkg::ACT_PUT, tcw_pkg::CODE_BACKSPACE, 11'd0}, 6'd1, 1'b0, '0},
        '{'{tcw_pkg::ACT_READ, 9'h000, 11'd2}, 6'd1, 1'b0, '0},
        '{'{tcw_pkg::ACT_PUT, tcw_pkg::CODE_NEWLINE, 11'd0}, 6'd1, 1'b1,
          '{11'd80, 16'h0000, 1'b0}},
        '{'{ACT_UNUSED, 9'h1FF, 11'd2047}, 6'd1, 1'b1, '{11'd80, 16'h0000, 1'b0}},
        '{'{tcw_pkg::ACT_CLEAR, 9'h000, 11'd0}, 6'd1, 1'b1, '{11'd0, 16'h0000, 1'b0}},
        '{'{tcw_pkg::ACT_PUT, tcw_pkg::CODE_BACKSPACE, 11'd0}, 6'd1, 1'b1,
          '{11'd0, 16'h0000, 1'b0}},
        '{'{tcw_pkg::ACT_READ, 9'h000, 11'd0}, 6'd1, 1'b1, '{11'd0, 16'h0F20, 1'b0}},
        '{'{tcw_pkg::ACT_PUT, tcw_pkg::CODE_NEWLINE, 11'd0}, 6'd23, 1'b0, '0},
        '{'{tcw_pkg::ACT_PUT, 9'h05A, 11'd0}, 6'd1, 1'b0, '0},
        '{'{tcw_pkg::ACT_PUT, tcw_pkg::CODE_NEWLINE, 11'd0}, 6'd1, 1'b1,
          '{11'd1840, 16'h0000, 1'b1}},
        '{'{tcw_pkg::ACT_READ, 9'h000, 11'd1760}, 6'd1, 1'b0, '0},
        '{'{tcw_pkg::ACT_READ, 9'h000, 11'd1840}, 6'd1, 1'b0, '0},
        '{'{tcw_pkg::ACT_READ, 9'h000, 11'd1999}, 6'd1, 1'b0, '0},
        '{'{tcw_pkg::ACT_CLEAR, 9'h1FF, 11'd1999}, 6'd1, 1'b1, '{11'd0, 16'h0000, 1'b0}}
    };

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    tcw_pkg::in_t               s_data;
    logic                       m_valid;
    logic                       m_ready;
    tcw_pkg::out_t              m_data;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [tcw_pkg::ATTR_W-1:0] cfg_data;

    // Shadow of the screen, cursor and attribute
    logic [tcw_pkg::CELL_W-1:0] screen_cells [0:CELL_COUNT-1];
    int                         cursor_now;
    logic [tcw_pkg::ATTR_W-1:0] text_attr;

    tcw_pkg::out_t console_results [$];
    int   fail_count = 0;
    int   idle_pct   = 10;
    int   stall_pct  = 49;
    bit   hold_req   = 1'b0;
    bit   hold_done  = 1'b0;
    int   quiet_cycles = 0;

    text_console_writer_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Apply one command to the shadow screen and work out its result
    task automatic console_step(input tcw_pkg::in_t cmd, output tcw_pkg::out_t res);
        int pos;
        res = '0;
        case (cmd.action)
            tcw_pkg::ACT_PUT: begin
                pos = cursor_now;
                if (cmd.char_code == tcw_pkg::CODE_NEWLINE) begin
                    pos += SCREEN_COLS - pos % SCREEN_COLS;
                end else if (cmd.char_code == tcw_pkg::CODE_BACKSPACE) begin
                    if (pos > 0) pos--;
                end else begin
                    if (pos < CELL_COUNT) screen_cells[pos] = {text_attr, cmd.char_code[7:0]};
                    pos++;
                end
                // scroll rows 1..ROWS-2 up by one, last row untouched
                if (pos >= SCROLL_LIMIT) begin
                    for (int k = 0; k < (SCREEN_ROWS - 2) * SCREEN_COLS; k++)
                        screen_cells[k] = screen_cells[k + SCREEN_COLS];
                    pos -= SCREEN_COLS;
                    for (int k = pos; k < SCROLL_LIMIT; k++)
                        screen_cells[k] = '0;
                    res.scrolled = 1'b1;
                end
                cursor_now = pos;
                if (pos < CELL_COUNT) screen_cells[pos] = {text_attr, tcw_pkg::BLANK_CHAR};
            end
            tcw_pkg::ACT_CLEAR: begin
                for (int k = 0; k < CELL_COUNT; k++)
                    screen_cells[k] = '0;
                cursor_now = 0;
            end
            tcw_pkg::ACT_READ: begin
                if (cmd.cell_index < CELL_COUNT) res.cell_data = screen_cells[cmd.cell_index];
            end
            default: ;
        endcase
        res.cursor_pos = cursor_now[tcw_pkg::POS_W-1:0];
    endtask

    // Random command; reads lean toward the cells at and behind the cursor
    function automatic tcw_pkg::in_t random_command();
        tcw_pkg::in_t cmd;
        int  roll;
        int  pick;
        cmd.char_code  = tcw_pkg::CODE_W'($urandom);
        cmd.cell_index = tcw_pkg::INDEX_W'($urandom);
        roll = $urandom_range(999);
        if (roll < 10) begin
            cmd.action = tcw_pkg::ACT_CLEAR;
        end else if (roll < 30) begin
            cmd.action = ACT_UNUSED;
        end else if (roll < 230) begin
            cmd.action = tcw_pkg::ACT_READ;
            pick = $urandom_range(99);
            if (pick < 5)
                cmd.cell_index = tcw_pkg::INDEX_W'($urandom_range(2047, CELL_COUNT));
            else if (pick < 50)
                cmd.cell_index = tcw_pkg::INDEX_W'($urandom_range(CELL_COUNT - 1));
            else
                cmd.cell_index = tcw_pkg::INDEX_W'(
                    (cursor_now + CELL_COUNT - $urandom_range(160)) % CELL_COUNT);
        end else begin
            cmd.action = tcw_pkg::ACT_PUT;
            pick = $urandom_range(99);
            if (pick < 6)
                cmd.char_code = tcw_pkg::CODE_NEWLINE;
            else if (pick < 10)
                cmd.char_code = tcw_pkg::CODE_BACKSPACE;
            else if (pick < 15)
                cmd.char_code = tcw_pkg::CODE_W'($urandom_range(511, 257));
            else
                cmd.char_code = tcw_pkg::CODE_W'($urandom_range(255));
        end
        return cmd;
    endfunction

    // Offer one command, wait for its transfer, record what it should return
    task automatic send_command(input tcw_pkg::in_t cmd, input bit use_fixed,
                                input tcw_pkg::out_t fixed_res);
        tcw_pkg::out_t res;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (s_ready !== 1'b1);
        console_step(cmd, res);
        console_results.push_back(use_fixed ? fixed_res : res);
    endtask

    // Stop offering and wait until every result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (console_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_attribute(input logic [tcw_pkg::ATTR_W-1:0] value);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        text_attr = value;
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Compare every result transfer with the oldest expectation
    always @(posedge aclk) begin : check_results
        tcw_pkg::out_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (console_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_data);
                fail_count++;
            end else begin
                want = console_results.pop_front();
                if (m_data.cursor_pos !== want.cursor_pos) begin
                    $error("cursor_pos expected %0d got %0d", want.cursor_pos, m_data.cursor_pos);
                    fail_count++;
                end
                if (m_data.cell_data !== want.cell_data) begin
                    $error("cell_data expected %h got %h", want.cell_data, m_data.cell_data);
                    fail_count++;
                end
                if (m_data.scrolled !== want.scrolled) begin
                    $error("scrolled expected %0b got %0b", want.scrolled, m_data.scrolled);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on stretches with no transfer on any channel
    always @(posedge aclk) begin
        if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1)
                || (cfg_valid === 1'b1 && cfg_ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [tcw_pkg::ATTR_W-1:0] attr_value;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        for (int k = 0; k < CELL_COUNT; k++)
            screen_cells[k] = '0;
        cursor_now = 0;
        text_attr  = tcw_pkg::ATTR_RESET;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed steps run on the attribute left by reset
        for (int r = 0; r < $size(DIRECTED_STEPS); r++)
            for (int n = 0; n < DIRECTED_STEPS[r].reps; n++)
                send_command(DIRECTED_STEPS[r].cmd, DIRECTED_STEPS[r].fixed,
                             DIRECTED_STEPS[r].want);

        // Random segments: two per idling mode, new attribute before each
        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            case (seg / 2)
                0: begin idle_pct = 10; stall_pct = 49; end
                1: begin idle_pct = 49; stall_pct = 10; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            if (seg == 0)
                attr_value = '0;
            else if (seg == 1)
                attr_value = '1;
            else
                attr_value = tcw_pkg::ATTR_W'($urandom_range(255));
            write_attribute(attr_value);
            for (int i = 0; i < SEG_ITEMS; i++) begin
                if (seg == 0 && i == 20) hold_req = 1'b1;
                if (seg == 3 && i == SEG_ITEMS / 2) wait_drained();
                send_command(random_command(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (console_results.size() != 0) begin
            $error("%0d results never arrived", console_results.size());
        end
        if (fail_count == 0 && console_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
src/tcw_pkg.sv
src/tcw_ram.sv
src/text_console_writer_core.sv
tb/sv/tb_text_console_writer_core.sv
